// ===== hdl/indexed_insert_delete_list_assert.svh =====
// Assertion macros shared by the indexed insert/delete list RTL.
`ifndef INDEXED_INSERT_DELETE_LIST_ASSERT_SVH
`define INDEXED_INSERT_DELETE_LIST_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define IDIL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("idil: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define IDIL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("idil: next-cycle check failed");

`else

`define IDIL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IDIL_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/idil_pkg.sv =====
// Shared types and constants of the indexed insert/delete list.
package idil_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 8;

	localparam logic [VALUE_W-1:0] READ_INVALID = '1;

	typedef enum logic [2:0] {
		REQ_READ     = 3'd0,
		REQ_INS_HEAD = 3'd1,
		REQ_INS_TAIL = 3'd2,
		REQ_INS_AT   = 3'd3,
		REQ_DELETE   = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2
	} cell_op_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		cell_op_t op;
		logic     rd_en;
	} cell_cmd_t;

endpackage

// ===== hdl/idil_cell.sv =====
// One positional cell of the list: hold, shift from a neighbor, or load.
module idil_cell import idil_pkg::*; #(
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  cell_cmd_t          cmd,
	input  logic [IW-1:0]      at_idx,
	input  logic [IW-1:0]      rd_idx,
	input  logic [VALUE_W-1:0] new_value,
	input  logic [VALUE_W-1:0] left_value,
	input  logic [VALUE_W-1:0] right_value,
	output logic [VALUE_W-1:0] value,
	output logic [VALUE_W-1:0] rd_data
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [VALUE_W-1:0] value_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INS: begin
				if (MY_IDX > at_idx) begin
					value_q <= left_value;
				end else if (MY_IDX == at_idx) begin
					value_q <= new_value;
				end
			end
			CELL_DEL: begin
				if (MY_IDX >= at_idx) begin
					value_q <= right_value;
				end
			end
			default: begin
			end
		endcase
	end

	assign value   = value_q;
	// drive the shared read bus only when addressed
	assign rd_data = (cmd.rd_en && (rd_idx == MY_IDX)) ? value_q : '0;

endmodule

// ===== hdl/indexed_insert_delete_list.sv =====
// Indexed insert/delete list: a chain of positional cells, head at cell 0.
// The result word is registered at the edge that accepts the request.
// Throughput: one request per cycle; every cell shifts, holds or loads in that same cycle.
// The output register frees when its word is taken, so input stall follows output stall.
// Reset (arst_n low) empties the list and drops any pending result; cell contents
// are not cleared and are never read before being written.
`include "indexed_insert_delete_list_assert.svh"

module indexed_insert_delete_list import idil_pkg::*; #(
	parameter int CAPACITY = 64,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic [POS_W-1:0]   position,
	input  logic [VALUE_W-1:0] item_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VALUE_W-1:0] read_value,
	output logic [1:0]         status,
	output logic [CW-1:0]      list_length
);

	// cell index width, and a compare width that covers both count and position
	localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMPW = (CW > POS_W - 1) ? CW : POS_W - 1;
	localparam logic [CMPW-1:0] CAP_EXT = CMPW'(CAPACITY);

	// control state
	logic [CW-1:0] count_q;
	logic          out_valid_q;

	// result word, held until taken
	logic [VALUE_W-1:0] read_value_q;
	status_t            status_q;
	logic [CW-1:0]      length_q;

	logic in_acc;
	logic out_free;

	// decode results
	cell_op_t           op_d;
	logic [IW-1:0]      at_d;
	status_t            st_d;
	logic [VALUE_W-1:0] rd_d;
	logic [CW-1:0]      count_d;
	logic               ins_req;
	logic               is_read;

	logic              pos_neg;
	logic [CMPW-1:0]   pos_ext;
	logic [CMPW-1:0]   cnt_ext;
	logic              idx_ok;
	logic              full;
	logic [IW-1:0]     pos_idx;

	cell_cmd_t          cmd;
	logic [VALUE_W-1:0] cell_val [CAPACITY];
	logic [VALUE_W-1:0] cell_rd  [CAPACITY];
	logic [VALUE_W-1:0] rd_bus;

	// handshake: accept whenever the result register is empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !out_free;
	assign in_acc   = in_valid && out_free;

	// position checks against the current length
	assign pos_neg = position[POS_W-1];
	assign pos_ext = CMPW'(position[POS_W-2:0]);
	assign cnt_ext = CMPW'(count_q);
	assign idx_ok  = !pos_neg && (pos_ext < cnt_ext);
	assign full    = (cnt_ext == CAP_EXT);
	assign pos_idx = IW'(pos_ext);

	always_comb begin
		op_d    = CELL_HOLD;
		at_d    = '0;
		st_d    = ST_DONE;
		rd_d    = '0;
		ins_req = 1'b0;
		is_read = 1'b0;
		count_d = count_q;
		case (req_t'(req_type))
			REQ_READ: begin
				is_read = 1'b1;
				if (idx_ok) begin
					rd_d = rd_bus;
				end else begin
					rd_d = READ_INVALID;
					st_d = ST_INVALID;
				end
			end
			REQ_INS_HEAD: begin
				ins_req = 1'b1;
			end
			REQ_INS_TAIL: begin
				ins_req = 1'b1;
				at_d    = IW'(count_q);
			end
			REQ_INS_AT: begin
				// negative or zero means head; past the end is ignored before any full check
				if (pos_neg || (pos_ext == '0)) begin
					ins_req = 1'b1;
				end else if (pos_ext <= cnt_ext) begin
					ins_req = 1'b1;
					at_d    = pos_idx;
				end else begin
					st_d = ST_INVALID;
				end
			end
			REQ_DELETE: begin
				if (idx_ok) begin
					op_d    = CELL_DEL;
					at_d    = pos_idx;
					count_d = count_q - 1'b1;
				end else begin
					st_d = ST_INVALID;
				end
			end
			default: begin
				st_d = ST_INVALID;
			end
		endcase
		if (ins_req) begin
			if (full) begin
				st_d = ST_FULL;
			end else begin
				op_d    = CELL_INS;
				count_d = count_q + 1'b1;
			end
		end
	end

	// cells move only on an accepted word
	assign cmd.op    = in_acc ? op_d : CELL_HOLD;
	assign cmd.rd_en = is_read;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_W-1:0] left_w;
		logic [VALUE_W-1:0] right_w;

		if (i == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_val[i+1];
		end

		idil_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.at_idx      (at_d),
			.rd_idx      (pos_idx),
			.new_value   (item_value),
			.left_value  (left_w),
			.right_value (right_w),
			.value       (cell_val[i]),
			.rd_data     (cell_rd[i])
		);
	end

	// at most one cell drives a nonzero word, so OR them together
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	// length register and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				count_q <= count_d;
			end
			if (out_free) begin
				out_valid_q <= in_acc;
			end
		end
	end

	// result payload: load on accept, hold while stalled
	always_ff @(posedge clk) begin
		if (in_acc) begin
			read_value_q <= rd_d;
			status_q     <= st_d;
			length_q     <= count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign list_length = length_q;

	`IDIL_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, CMPW'(count_q) <= CAP_EXT)
	`IDIL_ASSERT_IMP(a_full_only_at_cap, clk, arst_n, in_acc && (st_d == ST_FULL), full)
	`IDIL_ASSERT_NXT(a_ins_grows, clk, arst_n, in_acc && (cmd.op == CELL_INS), count_q == CW'($past(count_q) + 1'b1))
	`IDIL_ASSERT_NXT(a_invalid_holds, clk, arst_n, in_acc && (st_d != ST_DONE), $stable(count_q))

endmodule

// ===== tb/indexed_insert_delete_list_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the indexed insert/delete list.
module indexed_insert_delete_list_tb import idil_pkg::*; ();

	localparam int DEPTH        = 64;
	localparam int LEN_W        = $clog2(DEPTH + 1);
	localparam int MAX_WAIT     = 14;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_LIMIT = 10;

	// Request codes the block does not define; it must ignore them.
	localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REQ_SPARE_MID   = 3'd6;
	localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

	// One expected result word.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
		logic [LEN_W-1:0]   length;
	} list_reply_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         req_type;
	logic [POS_W-1:0]   position;
	logic [VALUE_W-1:0] item_value;
	logic               out_valid;
	logic               out_stall;
	logic [VALUE_W-1:0] read_value;
	logic [1:0]         status;
	logic [LEN_W-1:0]   list_length;

	// Shadow copy of the list, updated as each request word is accepted.
	logic [VALUE_W-1:0] shadow_cells [DEPTH];
	int                 shadow_count;
	int                 longest_list;

	// Results owed by the block, oldest first.
	list_reply_t reply_queue[$];

	// Idle control: each side may be switched to full speed for a stretch.
	bit send_idle;
	bit recv_idle;
	int stall_left;

	int cycle_count;
	int mismatch_count;
	int words_checked;
	int words_sent;
	int kind_seen [8];
	int status_seen [4];

	indexed_insert_delete_list #(
		.CAPACITY(DEPTH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.position   (position),
		.item_value (item_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.status     (status),
		.list_length(list_length)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop: no correct run comes near this many cycles.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles with %0d results pending",
			cycle_count, reply_queue.size());
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Open a slot at 'at' by shifting the tail up, then load the value.
	// The full check comes first, as in the block.
	function automatic status_t place_value(int at, logic [VALUE_W-1:0] val);
		if (shadow_count >= DEPTH)
			return ST_FULL;
		if (at > shadow_count)
			return ST_INVALID;
		for (int i = shadow_count; i > at; i--)
			shadow_cells[i] = shadow_cells[i-1];
		shadow_cells[at] = val;
		shadow_count++;
		return ST_DONE;
	endfunction

	// Apply one request to the shadow list and return the word it must produce.
	function automatic list_reply_t predict_reply(logic [2:0] kind,
			logic signed [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
		list_reply_t r;
		int          at;
		r.value  = '0;
		r.status = ST_DONE;
		at       = pos;
		case (kind)
			REQ_READ: begin
				if (at < 0 || at >= shadow_count) begin
					r.value  = READ_INVALID;
					r.status = ST_INVALID;
				end else begin
					r.value = shadow_cells[at];
				end
			end
			REQ_INS_HEAD: r.status = place_value(0, val);
			REQ_INS_TAIL: r.status = place_value(shadow_count, val);
			REQ_INS_AT: begin
				// Negative or zero goes to the head; past the end is ignored
				// even when the list is full.
				if (at <= 0)
					r.status = place_value(0, val);
				else if (at <= shadow_count)
					r.status = place_value(at, val);
				else
					r.status = ST_INVALID;
			end
			REQ_DELETE: begin
				if (at < 0 || at >= shadow_count) begin
					r.status = ST_INVALID;
				end else begin
					for (int i = at; i + 1 < shadow_count; i++)
						shadow_cells[i] = shadow_cells[i+1];
					shadow_count--;
				end
			end
			default: r.status = ST_INVALID;
		endcase
		r.length = LEN_W'(shadow_count);
		status_seen[r.status]++;
		if (shadow_count > longest_list)
			longest_list = shadow_count;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly indexes inside the list or just at its end, some just past it,
	// and some anywhere in the 8-bit range, negatives included.
	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return POS_W'($urandom_range(0, shadow_count));
		if (r == 7)
			return POS_W'(shadow_count + 1 + $urandom_range(0, 3));
		return POS_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 32'h8000_0000;
		if (r == 1)
			return 32'h7fff_ffff;
		return $urandom;
	endfunction

	// Insert share in percent; the rest splits among reads, deletes and
	// undefined codes.
	function automatic logic [2:0] pick_kind(int insert_pct);
		int r;
		int s;
		r = $urandom_range(0, 99);
		if (r < insert_pct) begin
			s = $urandom_range(0, 2);
			if (s == 0)
				return REQ_INS_HEAD;
			if (s == 1)
				return REQ_INS_TAIL;
			return REQ_INS_AT;
		end
		s = $urandom_range(0, 99);
		if (s < 45)
			return REQ_READ;
		if (s < 90)
			return REQ_DELETE;
		return 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
	endfunction

	// Send one request word. Entered and left at a rising edge. Valid is left
	// high on return so a back-to-back word needs no second assignment to it.
	task automatic send_word(input logic [2:0] kind, input logic [POS_W-1:0] pos,
			input logic [VALUE_W-1:0] val);
		int          gap;
		list_reply_t want;
		gap = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		position   <= pos;
		item_value <= val;
		// Stall is settled by the falling edge; the next rising edge takes the word.
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		want = predict_reply(kind, pos, val);
		reply_queue.push_back(want);
		words_sent++;
		kind_seen[kind]++;
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] seen);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch in %s of result %0d: expected %h, got %h",
				field, words_checked, want, seen);
	endtask

	// Hold out_stall for the count drawn when the last word was taken.
	initial begin
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Check each word at the falling edge before the rising edge that takes it;
	// outputs and stall are stable there.
	initial begin
		list_reply_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (reply_queue.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("result word with nothing pending: value %h status %0d length %0d",
							read_value, status, list_length);
				end else begin
					want = reply_queue.pop_front();
					if (read_value !== want.value)
						report_mismatch("read_value", want.value, read_value);
					if (status !== want.status)
						report_mismatch("status", VALUE_W'(want.status), VALUE_W'(status));
					if (list_length !== want.length)
						report_mismatch("list_length", VALUE_W'(want.length),
							VALUE_W'(list_length));
				end
				words_checked++;
				stall_left = recv_idle ? $urandom_range(0, MAX_WAIT) : 0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked words: empty list, each insert flavor, bounds, undefined codes.
	task automatic test_directed_cases();
		send_idle = 1'b1;
		recv_idle = 1'b1;
		send_word(REQ_READ,     8'sd0,    32'h0);          // read on empty list
		send_word(REQ_DELETE,   8'sd0,    32'h0);          // delete on empty list
		send_word(REQ_INS_AT,   8'sd5,    32'h1234_5678);  // insert past the end
		send_word(REQ_INS_AT,   -8'sd128, 32'h8000_0000);  // negative index goes to head
		send_word(REQ_INS_TAIL, 8'sd0,    32'h7fff_ffff);
		send_word(REQ_INS_HEAD, 8'sd0,    32'h0000_0000);
		send_word(REQ_INS_AT,   8'sd3,    32'hffff_ffff);  // index equal to length appends
		send_word(REQ_INS_AT,   8'sd0,    32'h5a5a_5a5a);  // zero index goes to head
		send_word(REQ_INS_AT,   8'sd2,    32'ha5a5_a5a5);  // middle
		send_word(REQ_READ,     8'sd0,    32'hffff_ffff);
		send_word(REQ_READ,     8'sd5,    32'h0);
		send_word(REQ_READ,     8'sd127,  32'h0);          // far past the end
		send_word(REQ_READ,     -8'sd1,   32'h0);          // negative read
		send_word(REQ_READ,     8'sd6,    32'h0);          // index equal to length
		send_word(REQ_DELETE,   -8'sd128, 32'h0);
		send_word(REQ_DELETE,   8'sd6,    32'h0);
		send_word(REQ_DELETE,   8'sd5,    32'h0);          // last entry
		send_word(REQ_DELETE,   8'sd0,    32'h0);          // head
		send_word(REQ_DELETE,   8'sd1,    32'h0);          // middle
		send_word(REQ_SPARE_FIRST, 8'sd0,  32'hdead_beef);
		send_word(REQ_SPARE_MID,   -8'sd1, 32'h0);
		send_word(REQ_SPARE_LAST,  8'sd1,  32'hffff_ffff);
		send_word(REQ_INS_AT,   8'sd127,  32'h1);
		send_word(REQ_READ,     8'sd2,    32'h0);
	endtask

	// Grow the list to capacity, then hammer it with inserts that must be
	// refused and with past-end inserts that are ignored instead.
	task automatic test_fill_to_full();
		send_idle = 1'b1;
		recv_idle = 1'b0;
		while (shadow_count < DEPTH)
			send_word(pick_kind(80), pick_position(), pick_value());
		recv_idle = 1'b1;
		repeat (14)
			send_word(pick_kind(100), pick_position(), pick_value());
		send_word(REQ_INS_AT, POS_W'(DEPTH + 1), pick_value());
		send_word(REQ_READ,   POS_W'(DEPTH - 1), pick_value());
		send_word(REQ_READ,   POS_W'(DEPTH),     pick_value());
		send_word(REQ_DELETE, POS_W'(DEPTH),     pick_value());
	endtask

	// Empty the list again with reads, deletes and undefined codes only, then
	// poke at the empty state.
	task automatic test_drain_to_empty();
		send_idle = 1'b0;
		recv_idle = 1'b1;
		while (shadow_count > 0)
			send_word(pick_kind(0), pick_position(), pick_value());
		send_idle = 1'b1;
		repeat (6)
			send_word(pick_kind(30), pick_position(), pick_value());
	endtask

	// Blocks of random words; each block picks an insert bias so the length
	// swings between empty and full, and an idle mode for each side.
	task automatic test_random_mix(input int blocks, input int per_block);
		int mode;
		int bias;
		for (int b = 0; b < blocks; b++) begin
			mode      = $urandom_range(0, 3);
			send_idle = (mode == 0 || mode == 2);
			recv_idle = (mode == 0 || mode == 3);
			bias      = 20 + 15 * $urandom_range(0, 4);
			repeat (per_block)
				send_word(pick_kind(bias), pick_position(), pick_value());
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		req_type       <= REQ_READ;
		position       <= '0;
		item_value     <= '0;
		send_idle      = 1'b1;
		recv_idle      = 1'b1;
		shadow_count   = 0;
		longest_list   = 0;
		mismatch_count = 0;
		words_checked  = 0;
		words_sent     = 0;
		foreach (kind_seen[k])
			kind_seen[k] = 0;
		foreach (status_seen[s])
			status_seen[s] = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_fill_to_full();
		test_drain_to_empty();
		test_random_mix(4, 40);
		test_fill_to_full();
		test_drain_to_empty();

		// Drop valid and wait out the results still owed.
		in_valid <= 1'b0;
		while (reply_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d reads, %0d head, %0d tail, %0d indexed inserts, %0d deletes, %0d undefined",
			words_sent, kind_seen[REQ_READ], kind_seen[REQ_INS_HEAD],
			kind_seen[REQ_INS_TAIL], kind_seen[REQ_INS_AT], kind_seen[REQ_DELETE],
			kind_seen[REQ_SPARE_FIRST] + kind_seen[REQ_SPARE_MID] +
			kind_seen[REQ_SPARE_LAST]);
		$display("%0d refused as full, %0d ignored as invalid, longest list %0d of %0d, %0d mismatches",
			status_seen[ST_FULL], status_seen[ST_INVALID], longest_list, DEPTH,
			mismatch_count);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
